// ===== design/nearest_neighbour_rgb565_scaler_defines.svh =====
// Assertion macros shared by the scaler checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef NEAREST_NEIGHBOUR_RGB565_SCALER_DEFINES_SVH
`define NEAREST_NEIGHBOUR_RGB565_SCALER_DEFINES_SVH

// same-cycle implication, off while reset is high
`define NNSCL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error(msg);

// next-cycle implication, off while reset is high
`define NNSCL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error(msg);

// what must hold in the cycle after reset
`define NNSCL_ASSERT_RST(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
   else $error(msg);

`endif

// ===== design/nnscl_pkg.sv =====
// Shared types, constants and helpers of the RGB565 nearest-neighbor scaler.
// No dependencies.
package nnscl_pkg;

   localparam int DIM_W               = 11;
   localparam int MAX_DIMENSION       = 1024;
   localparam int SOURCE_CAPACITY_DEF = 65536;
   localparam int PROD_W              = 2 * DIM_W;
   localparam int DEST_W              = 20;
   localparam int PIX_W               = 16;
   localparam int FRONT_DEPTH         = 4;
   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

   typedef enum logic [1:0] {
      CSR_SOURCE_WIDTH  = 2'd0,
      CSR_SOURCE_HEIGHT = 2'd1,
      CSR_TARGET_WIDTH  = 2'd2,
      CSR_TARGET_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EMIT = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_START,
      BK_DIV,
      BK_ADDR,
      BK_READ,
      BK_RESULT
   } back_state_type;

   typedef struct packed {
      logic       func;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [DEST_W-1:0] dest_index;
      logic [PIX_W-1:0]  pixel_value;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0] sw;
      logic [DIM_W-1:0] sh;
      logic [DIM_W-1:0] tw;
      logic [DIM_W-1:0] th;
   } dims_type;

   typedef struct packed {
      op_type           op;
      logic [PIX_W-1:0] pixel;
   } work_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIMENSION)) begin
         r = DIM_W'(MAX_DIMENSION);
      end
      return r;
   endfunction

   function automatic logic [PIX_W-1:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

endpackage

// ===== design/nnscl_front.sv =====
// Front end: input queue that classifies each beat and packs its color to R5G6B5.
// Depends on nnscl_pkg.
module nnscl_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  nnscl_pkg::req_type req_data,
   output logic               work_valid,
   input  logic               work_pop,
   output nnscl_pkg::work_type work
);
   import nnscl_pkg::*;

   localparam int PTR_W = $clog2(FRONT_DEPTH);
   localparam int CNT_W = $clog2(FRONT_DEPTH + 1);

   work_type             entry_ff [FRONT_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;
   work_type             classified;

   assign req_full   = (count_ff == CNT_W'(FRONT_DEPTH));
   assign work_valid = (count_ff != '0);
   assign work       = entry_ff[rd_ptr_ff];
   assign do_push    = req_push && !req_full;
   assign do_pop     = work_pop && work_valid;

   always_comb begin
      classified.op    = op_type'(req_data.func);
      classified.pixel = pack565(req_data.red, req_data.green, req_data.blue);
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// ===== design/nnscl_div.sv =====
// Restoring divider, one quotient bit per cycle, for quotients known to fit DIM_W bits.
// Depends on nnscl_pkg.
module nnscl_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [nnscl_pkg::PROD_W-1:0] dividend,
   input  logic [nnscl_pkg::DIM_W-1:0]  divisor,
   output logic                         busy,
   output logic [nnscl_pkg::DIM_W-1:0]  quotient
);
   import nnscl_pkg::*;

   localparam int CNT_W = $clog2(DIM_W + 1);

   logic [DIM_W-1:0] rem_ff, rem_in;
   logic [DIM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DIM_W:0]   trial;
   logic             take;

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   always_comb begin
      // quo_ff holds the remaining dividend bits on top, quotient bits shift in below
      trial   = {rem_ff, quo_ff[DIM_W-1]};
      take    = (trial >= {1'b0, divisor});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         // upper half is below the divisor since the quotient fits DIM_W bits
         rem_in  = dividend[PROD_W-1:DIM_W];
         quo_in  = dividend[DIM_W-1:0];
         cnt_in  = CNT_W'(DIM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = take ? DIM_W'(trial - {1'b0, divisor}) : trial[DIM_W-1:0];
         quo_in  = {quo_ff[DIM_W-2:0], take};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

// ===== design/nnscl_back.sv =====
// Back end: frame memory, destination walk, coordinate mapping and result register.
// Depends on nnscl_pkg and nnscl_div.
module nnscl_back #(
   parameter int SOURCE_CAPACITY = nnscl_pkg::SOURCE_CAPACITY_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  nnscl_pkg::dims_type dims,
   input  logic                work_valid,
   output logic                work_pop,
   input  nnscl_pkg::work_type work,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output nnscl_pkg::rsp_type  rsp_data
);
   import nnscl_pkg::*;

   localparam int AW    = $clog2(SOURCE_CAPACITY);
   localparam int CNT_W = $clog2(SOURCE_CAPACITY + 1);

   back_state_type    state_ff, state_in;
   logic [DIM_W-1:0]  col_ff, col_in;
   logic [DIM_W-1:0]  row_ff, row_in;
   logic [CNT_W-1:0]  load_cnt_ff, load_cnt_in;
   logic              out_valid_ff, out_valid_in;

   logic [PIX_W-1:0]  mem [SOURCE_CAPACITY];
   logic [PIX_W-1:0]  rd_data_ff;
   logic [PROD_W-1:0] nx_ff, ny_ff, dprod_ff, src_ff;
   logic [DEST_W-1:0] dest_ff;
   logic              last_ff, beyond_ff;
   rsp_type           out_data_ff;

   logic              mem_we;
   logic              div_start;
   logic              out_load;
   logic              busy_x, busy_y;
   logic [DIM_W-1:0]  qx, qy;
   logic [DIM_W-1:0]  row_inc, col_inc;
   logic [PROD_W-1:0] src_in;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign row_inc   = row_ff + 1'b1;
   assign col_inc   = col_ff + 1'b1;
   assign src_in    = PROD_W'(qy) * PROD_W'(dims.sw) + PROD_W'(qx);

   nnscl_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (nx_ff),
      .divisor  (dims.tw),
      .busy     (busy_x),
      .quotient (qx)
   );

   nnscl_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ny_ff),
      .divisor  (dims.th),
      .busy     (busy_y),
      .quotient (qy)
   );

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      load_cnt_in  = load_cnt_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      work_pop     = 1'b0;
      mem_we       = 1'b0;
      div_start    = 1'b0;
      out_load     = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (work_valid) begin
               work_pop = 1'b1;
               if (work.op == OP_LOAD) begin
                  if (load_cnt_ff < CNT_W'(SOURCE_CAPACITY)) begin
                     mem_we      = 1'b1;
                     load_cnt_in = load_cnt_ff + 1'b1;
                  end
               end else if (row_ff < dims.th) begin
                  // width shrunk below the current column: go to the next row first
                  if (col_ff >= dims.tw) begin
                     col_in = '0;
                     row_in = row_inc;
                     if (row_inc < dims.th) begin
                        state_in = BK_MUL;
                     end
                  end else begin
                     state_in = BK_MUL;
                  end
               end
            end
         end
         BK_MUL: begin
            state_in = BK_START;
         end
         BK_START: begin
            div_start = 1'b1;
            state_in  = BK_DIV;
         end
         BK_DIV: begin
            if (!busy_x && !busy_y) begin
               state_in = BK_ADDR;
            end
         end
         BK_ADDR: begin
            state_in = BK_READ;
         end
         BK_READ: begin
            state_in = BK_RESULT;
         end
         BK_RESULT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_load     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = BK_IDLE;
               if (col_inc >= dims.tw) begin
                  col_in = '0;
                  row_in = row_inc;
               end else begin
                  col_in = col_inc;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         load_cnt_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         load_cnt_ff  <= load_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_MUL) begin
         nx_ff    <= PROD_W'(col_ff) * PROD_W'(dims.sw);
         ny_ff    <= PROD_W'(row_ff) * PROD_W'(dims.sh);
         dprod_ff <= PROD_W'(dims.th - 1'b1 - row_ff) * PROD_W'(dims.tw);
         last_ff  <= (row_ff == dims.th - 1'b1) && (col_ff == dims.tw - 1'b1);
      end
      if (state_ff == BK_ADDR) begin
         src_ff    <= src_in;
         dest_ff   <= DEST_W'(dprod_ff + PROD_W'(col_ff));
         beyond_ff <= (32'(src_in) >= 32'(SOURCE_CAPACITY));
      end
      if (out_load) begin
         out_data_ff.dest_index  <= dest_ff;
         out_data_ff.pixel_value <= beyond_ff ? '0 : rd_data_ff;
         out_data_ff.last        <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[load_cnt_ff[AW-1:0]] <= work.pixel;
      end
      if (state_ff == BK_READ) begin
         rd_data_ff <= mem[src_ff[AW-1:0]];
      end
   end

endmodule

// ===== design/nearest_neighbour_rgb565_scaler.sv =====
// Top level of the RGB565 nearest-neighbor scaler: size registers, front and back ends.
// Depends on nnscl_pkg, nnscl_front, nnscl_back.
//
// Usage:
//  - req channel (req_push/req_full): func 0 loads the next source texel (RGB888,
//    stored as R5G6B5 in raster order), func 1 emits the next destination pixel.
//  - rsp channel (rsp_empty/rsp_pop): one beat per emitted pixel with its
//    bottom-row-first index, the R5G6B5 value and a flag on the final pixel.
//  - csr port: four size registers, written with csr_wr_en; index 0 source width,
//    1 source height, 2 target width, 3 target height. Write only while idle.
// Flow: a four-entry input queue decouples intake from the back end. A load is
// handled in the idle state alone. An emit steps through the multiply, start,
// divide, address, read and result states, the two restoring dividers (one
// quotient bit per cycle, 11 bits) mapping the pixel to its source column and
// row before one frame memory read; its result is registered onto rsp_*.
// Reset clears the walk position, the load count and the queues, and sets all
// sizes to 256; the frame memory keeps its contents and needs no clearing.
// While the result register is held by a stalled receiver, loads keep
// flowing; the next emit waits only at its final step.
module nearest_neighbour_rgb565_scaler #(
   parameter int SOURCE_CAPACITY = nnscl_pkg::SOURCE_CAPACITY_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  nnscl_pkg::req_type            req_data,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output nnscl_pkg::rsp_type            rsp_data,
   input  logic                          csr_wr_en,
   input  nnscl_pkg::csr_index_type      csr_index,
   input  logic [nnscl_pkg::DIM_W-1:0]   csr_wdata
);
   import nnscl_pkg::*;

   dims_type dims_ff, dims_in;
   logic     work_valid;
   logic     work_pop;
   work_type work;

   // sizes are kept already clamped to 1..MAX_DIMENSION
   always_comb begin
      dims_in = dims_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SOURCE_WIDTH:  dims_in.sw = clamp_dim(csr_wdata);
            CSR_SOURCE_HEIGHT: dims_in.sh = clamp_dim(csr_wdata);
            CSR_TARGET_WIDTH:  dims_in.tw = clamp_dim(csr_wdata);
            CSR_TARGET_HEIGHT: dims_in.th = clamp_dim(csr_wdata);
            default: dims_in = dims_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= '{sw: DIM_RESET, sh: DIM_RESET, tw: DIM_RESET, th: DIM_RESET};
      end else begin
         dims_ff <= dims_in;
      end
   end

   nnscl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .work_valid (work_valid),
      .work_pop   (work_pop),
      .work       (work)
   );

   nnscl_back #(
      .SOURCE_CAPACITY (SOURCE_CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .dims       (dims_ff),
      .work_valid (work_valid),
      .work_pop   (work_pop),
      .work       (work),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== design/nnscl_checker.sv =====
// Port-level checks of the scaler, bound to the top level.
// Depends on nnscl_pkg and the scaler assertion macros header.
`include "nearest_neighbour_rgb565_scaler_defines.svh"

module nnscl_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_push,
   input logic               req_full,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input nnscl_pkg::rsp_type rsp_data
);

   `NNSCL_ASSERT_RST(a_reset_clears, clock, reset, rsp_empty && !req_full, "queues not cleared by reset")

   // an emit needs the whole back-end walk, so no result right after reset
   `NNSCL_ASSERT_IMP(a_no_early_result, clock, reset, $fell(rsp_empty), !$past(reset) && !$past(reset, 2), "result too soon after reset")

   // the input queue fills only on an accepted beat
   `NNSCL_ASSERT_IMP(a_full_on_push, clock, reset, $rose(req_full), $past(req_push && !req_full), "queue went full without a push")

   `NNSCL_ASSERT_NXT(a_result_held, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data), "stalled result beat changed")

endmodule

bind nearest_neighbour_rgb565_scaler nnscl_checker u_nnscl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

// ===== bench/nearest_neighbour_rgb565_scaler_test.sv =====
// Self-checking bench for the RGB565 nearest-neighbor scaler: directed and random beats,
// predicted in the bench and checked beat by beat on the result queue.
// Depends on nnscl_pkg and nearest_neighbour_rgb565_scaler.
module nearest_neighbour_rgb565_scaler_test;
   timeunit 1ns;
   timeprecision 1ps;
   import nnscl_pkg::*;

   localparam int unsigned STORE_DEPTH  = SOURCE_CAPACITY_DEF;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned DRAIN_CYCLES = 60;
   localparam int unsigned PHASE_BEATS  = 54;
   localparam int unsigned ROW_BUDGET   = 38;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_push  = 1'b0;
   logic             req_full;
   req_type          req_data  = '0;
   logic             rsp_empty;
   logic             rsp_pop   = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en = 1'b0;
   csr_index_type    csr_index = CSR_SOURCE_WIDTH;
   logic [DIM_W-1:0] csr_wdata = '0;

   // bench copy of the scaler state
   logic [PIX_W-1:0] texel_store [STORE_DEPTH];
   int unsigned      texels_loaded = 0;
   int unsigned      walk_col      = 0;
   int unsigned      walk_row      = 0;
   logic [DIM_W-1:0] size_reg [4]  = '{DIM_RESET, DIM_RESET, DIM_RESET, DIM_RESET};

   req_type          pending_beats [$];
   rsp_type          pixel_expect [$];
   int unsigned      send_gap_pct  = 0;
   int unsigned      pop_stall_pct = 0;
   int unsigned      cycle_count   = 0;
   int unsigned      failures      = 0;
   logic             req_accepted  = 1'b0;

   nearest_neighbour_rgb565_scaler u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_DIMENSION) return MAX_DIMENSION;
      return int'(v);
   endfunction

   // load appends a packed texel, emit walks the target raster
   function automatic void scale_beat(input req_type beat);
      int unsigned sw, sh, tw, th, sx, sy, src;
      rsp_type     pix;
      if (beat.func == OP_LOAD) begin
         if (texels_loaded < STORE_DEPTH) begin
            texel_store[texels_loaded] = (16'(beat.red & 8'hF8) << 8)
                                       | (16'(beat.green & 8'hFC) << 3)
                                       | 16'(beat.blue >> 3);
            texels_loaded++;
         end
         return;
      end
      sw = eff_dim(size_reg[CSR_SOURCE_WIDTH]);
      sh = eff_dim(size_reg[CSR_SOURCE_HEIGHT]);
      tw = eff_dim(size_reg[CSR_TARGET_WIDTH]);
      th = eff_dim(size_reg[CSR_TARGET_HEIGHT]);
      if (walk_row >= th) return;
      // width shrunk under the walk: skip to the next row
      if (walk_col >= tw) begin
         walk_col = 0;
         walk_row++;
         if (walk_row >= th) return;
      end
      sx = walk_col * sw / tw;
      sy = walk_row * sh / th;
      src = sy * sw + sx;
      pix.dest_index  = DEST_W'((th - 1 - walk_row) * tw + walk_col);
      pix.pixel_value = (src < STORE_DEPTH) ? texel_store[src] : '0;
      pix.last        = (walk_row == th - 1) && (walk_col == tw - 1);
      pixel_expect.push_back(pix);
      walk_col++;
      if (walk_col >= tw) begin
         walk_col = 0;
         walk_row++;
      end
   endfunction

   // intake, result check and watchdog, all on the rising edge
   always @(posedge clock) begin : watch_beats
      rsp_type want;
      if (!reset) begin
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end else begin
            if (!rsp_empty && rsp_pop) begin
               if (pixel_expect.size() == 0) begin
                  failures++;
                  $display("%0t: unexpected beat index %0d value %h last %b", $time,
                           rsp_data.dest_index, rsp_data.pixel_value, rsp_data.last);
               end else begin
                  want = pixel_expect.pop_front();
                  if (rsp_data.dest_index !== want.dest_index
                      || rsp_data.pixel_value !== want.pixel_value
                      || rsp_data.last !== want.last) begin
                     failures++;
                     $display("%0t: expected index %0d value %h last %b, got %0d %h %b",
                              $time, want.dest_index, want.pixel_value, want.last,
                              rsp_data.dest_index, rsp_data.pixel_value, rsp_data.last);
                  end
               end
            end
            if (req_push && !req_full) scale_beat(req_data);
         end
      end
      req_accepted <= !reset && req_push && !req_full;
   end

   // sender and receiver, on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         rsp_pop  <= 1'b0;
      end else begin
         if (!req_push || req_accepted) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req_push <= 1'b1;
               req_data <= pending_beats.pop_front();
            end else begin
               req_push <= 1'b0;
            end
         end
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   task automatic set_pace(input int unsigned mode);
      case (mode)
         0: begin send_gap_pct = 0;  pop_stall_pct = 0;  end
         1: begin send_gap_pct = 49; pop_stall_pct = 0;  end
         2: begin send_gap_pct = 0;  pop_stall_pct = 49; end
         default: begin send_gap_pct = 17; pop_stall_pct = 17; end
      endcase
   endtask

   // wait until every beat is in and every pixel is out, then let loads retire
   task automatic settle();
      while (pending_beats.size() != 0 || req_push || pixel_expect.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input csr_index_type idx, input logic [DIM_W-1:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      size_reg[idx] = v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_beat(input op_type op, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
      req_type beat;
      beat.func  = op;
      beat.red   = r;
      beat.green = g;
      beat.blue  = b;
      pending_beats.push_back(beat);
   endtask

   task automatic queue_random(input op_type op);
      queue_beat(op, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic random_phase(input int unsigned mode);
      int unsigned tw_eff, need, planned, emit_cap, emits, emit_pct;
      set_pace(mode);
      write_size(CSR_SOURCE_WIDTH, DIM_W'($urandom_range(16, 0)));
      write_size(CSR_SOURCE_HEIGHT, DIM_W'($urandom_range(16, 0)));
      emit_pct = 50;
      case ($urandom_range(9))
         0: write_size(CSR_TARGET_WIDTH, '0);
         1: write_size(CSR_TARGET_WIDTH, DIM_W'(1));
         2: write_size(CSR_TARGET_WIDTH, DIM_W'(MAX_DIMENSION));
         3: write_size(CSR_TARGET_WIDTH, DIM_W'(2047));
         default: write_size(CSR_TARGET_WIDTH, DIM_W'($urandom_range(40, 2)));
      endcase
      // keep the image unfinished: enough rows beyond this phase's walk
      case ($urandom_range(3))
         0: write_size(CSR_TARGET_HEIGHT, DIM_W'(2047));
         1: write_size(CSR_TARGET_HEIGHT, DIM_W'(MAX_DIMENSION));
         default: write_size(CSR_TARGET_HEIGHT,
                             DIM_W'($urandom_range(MAX_DIMENSION, walk_row + 41)));
      endcase
      tw_eff = eff_dim(size_reg[CSR_TARGET_WIDTH]);
      // every source texel an emit can reach must be loaded first
      need = eff_dim(size_reg[CSR_SOURCE_WIDTH]) * eff_dim(size_reg[CSR_SOURCE_HEIGHT]);
      if (need > STORE_DEPTH) need = STORE_DEPTH;
      for (planned = texels_loaded; planned < need; planned++) queue_random(OP_LOAD);
      emit_cap = ROW_BUDGET * tw_eff;
      emits = 0;
      for (int unsigned i = 0; i < PHASE_BEATS; i++) begin
         if ($urandom_range(99) < emit_pct && emits < emit_cap) begin
            queue_random(OP_EMIT);
            emits++;
         end else begin
            queue_random(OP_LOAD);
         end
      end
      settle();
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed: 2x2 source upscaled, packing corners of the channel ranges
      set_pace(0);
      write_size(CSR_SOURCE_WIDTH, DIM_W'(2));
      write_size(CSR_SOURCE_HEIGHT, DIM_W'(2));
      write_size(CSR_TARGET_WIDTH, DIM_W'(3));
      write_size(CSR_TARGET_HEIGHT, DIM_W'(MAX_DIMENSION));
      queue_beat(OP_LOAD, 8'h00, 8'h00, 8'h00);
      queue_beat(OP_LOAD, 8'hFF, 8'hFF, 8'hFF);
      queue_beat(OP_LOAD, 8'h07, 8'h03, 8'h07);
      queue_beat(OP_LOAD, 8'hF8, 8'hFC, 8'hF8);
      queue_beat(OP_LOAD, 8'h55, 8'hAA, 8'h33);
      repeat (7) queue_random(OP_EMIT);
      settle();
      // zero sizes act as one; the walk sits mid-row, so it wraps to the next row
      write_size(CSR_SOURCE_WIDTH, '0);
      write_size(CSR_SOURCE_HEIGHT, '0);
      write_size(CSR_TARGET_WIDTH, '0);
      write_size(CSR_TARGET_HEIGHT, DIM_W'(2047));
      queue_beat(OP_EMIT, 8'hFF, 8'hFF, 8'hFF);
      queue_random(OP_LOAD);
      queue_beat(OP_EMIT, 8'h00, 8'h00, 8'h00);
      queue_random(OP_EMIT);
      settle();

      for (int unsigned p = 0; p < 14; p++) begin
         if (p == 6) begin
            // source rows past the frame store read as zero: the walk is several rows
            // down, so every source row it maps to lies beyond the stored texels
            set_pace(0);
            write_size(CSR_SOURCE_WIDTH, DIM_W'(MAX_DIMENSION));
            write_size(CSR_SOURCE_HEIGHT, DIM_W'(2047));
            write_size(CSR_TARGET_WIDTH, DIM_W'(4));
            write_size(CSR_TARGET_HEIGHT, DIM_W'(walk_row + 8));
            repeat (6) queue_random(OP_EMIT);
            settle();
         end
         random_phase(p % 4);
      end

      // finish the image: last flag, then emits that give nothing
      set_pace(3);
      write_size(CSR_TARGET_WIDTH, DIM_W'(4));
      write_size(CSR_TARGET_HEIGHT, DIM_W'(walk_row + 2));
      repeat (14) queue_random(OP_EMIT);
      queue_random(OP_LOAD);
      settle();
      write_size(CSR_TARGET_HEIGHT, '0);
      write_size(CSR_SOURCE_WIDTH, DIM_W'(2047));
      repeat (4) queue_random(OP_EMIT);
      settle();

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/nnscl_pkg.sv
design/nnscl_front.sv
design/nnscl_div.sv
design/nnscl_back.sv
design/nearest_neighbour_rgb565_scaler.sv
design/nnscl_checker.sv
bench/nearest_neighbour_rgb565_scaler_test.sv
